// ===== src/mpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the multilevel priority run queue.
// No dependencies; every other file refers to this package by scoped names.

package mpq_pkg;

    // Sizing
    localparam int LEVELS      = 4;
    localparam int QUEUE_DEPTH = 32;
    localparam int ID_W        = 8;
    localparam int KIND_W      = 2;
    localparam int PRIO_W      = 2;
    localparam int STATUS_W    = 2;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((ID_W + PRIO_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + PRIO_W + STATUS_W + 7) / 8) * 8;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PICK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Access from the level control to the id store
    typedef struct packed {
        logic              adv;
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic [ID_W-1:0]   wr_data;
    } mpq_mem_req_t;

    // Circular slot advance
    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    // Flat store address of a slot in a level
    function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [SLOT_W-1:0] slot);
        return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage

// ===== src/mpq_level_ctrl.sv =====
`timescale 1ns / 1ps
// Per-level head, tail and count registers, priority encode and request decode.
// Depends on mpq_pkg; drives the store access and the result status fields.

module mpq_level_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [mpq_pkg::KIND_W-1:0]     kind,
    input  logic [mpq_pkg::ID_W-1:0]       thread_id,
    input  logic [mpq_pkg::PRIO_W-1:0]     priority_req,
    output mpq_pkg::mpq_mem_req_t          mem_req,
    output logic [mpq_pkg::PRIO_W-1:0]     next_priority,
    output logic [mpq_pkg::STATUS_W-1:0]   status
);

    logic [mpq_pkg::SLOT_W-1:0] head_reg  [mpq_pkg::LEVELS];
    logic [mpq_pkg::SLOT_W-1:0] tail_reg  [mpq_pkg::LEVELS];
    logic [mpq_pkg::CNT_W-1:0]  count_reg [mpq_pkg::LEVELS];

    logic [mpq_pkg::LVL_W-1:0]  enq_lvl;
    logic [mpq_pkg::LVL_W-1:0]  pick_lvl;
    logic [mpq_pkg::SLOT_W-1:0] tail_sel;
    logic [mpq_pkg::SLOT_W-1:0] head_sel;
    logic                       enq_full;
    logic                       any_ready;
    logic                       is_enq;
    logic                       is_pick;
    logic                       is_flush;
    logic                       enq_ok;
    logic                       pick_ok;

    assign is_enq   = (kind == mpq_pkg::KIND_ENQUEUE);
    assign is_pick  = (kind == mpq_pkg::KIND_PICK);
    assign is_flush = (kind == mpq_pkg::KIND_FLUSH);

    // Requested level, saturated to the top level
    always_comb begin
        if (int'(priority_req) >= mpq_pkg::LEVELS) begin
            enq_lvl = mpq_pkg::LVL_W'(mpq_pkg::LEVELS - 1);
        end else begin
            enq_lvl = mpq_pkg::LVL_W'(priority_req);
        end
    end

    // Highest non-empty level; later (higher) levels override lower ones
    always_comb begin
        any_ready = 1'b0;
        pick_lvl  = '0;
        for (int i = 0; i < mpq_pkg::LEVELS; i++) begin
            if (count_reg[i] != '0) begin
                any_ready = 1'b1;
                pick_lvl  = mpq_pkg::LVL_W'(i);
            end
        end
    end

    // Head and tail of the selected levels
    always_comb begin
        tail_sel = '0;
        head_sel = '0;
        enq_full = 1'b0;
        for (int i = 0; i < mpq_pkg::LEVELS; i++) begin
            if (enq_lvl == mpq_pkg::LVL_W'(i)) begin
                tail_sel = tail_reg[i];
                enq_full = (count_reg[i] == mpq_pkg::CNT_W'(mpq_pkg::QUEUE_DEPTH));
            end
            if (pick_lvl == mpq_pkg::LVL_W'(i)) begin
                head_sel = head_reg[i];
            end
        end
    end

    assign enq_ok  = is_enq && !enq_full;
    assign pick_ok = is_pick && any_ready;

    // Store access
    always_comb begin
        mem_req.adv     = accept;
        mem_req.wr_en   = accept && enq_ok;
        mem_req.rd_en   = pick_ok;
        mem_req.wr_addr = mpq_pkg::store_addr(enq_lvl, tail_sel);
        mem_req.rd_addr = mpq_pkg::store_addr(pick_lvl, head_sel);
        mem_req.wr_data = thread_id;
    end

    // Result status and demoted priority
    always_comb begin
        status        = mpq_pkg::ST_OK;
        next_priority = '0;
        if (is_enq && enq_full) begin
            status = mpq_pkg::ST_FULL;
        end else if (is_pick && !any_ready) begin
            status = mpq_pkg::ST_EMPTY;
        end else if (pick_ok && (pick_lvl != '0)) begin
            next_priority = mpq_pkg::PRIO_W'(pick_lvl - mpq_pkg::LVL_W'(1));
        end
    end

    // Level state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mpq_pkg::LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < mpq_pkg::LEVELS; i++) begin
                if (is_flush) begin
                    head_reg[i]  <= '0;
                    tail_reg[i]  <= '0;
                    count_reg[i] <= '0;
                end else if (enq_ok && (enq_lvl == mpq_pkg::LVL_W'(i))) begin
                    tail_reg[i]  <= mpq_pkg::slot_next(tail_reg[i]);
                    count_reg[i] <= count_reg[i] + mpq_pkg::CNT_W'(1);
                end else if (pick_ok && (pick_lvl == mpq_pkg::LVL_W'(i))) begin
                    head_reg[i]  <= mpq_pkg::slot_next(head_reg[i]);
                    count_reg[i] <= count_reg[i] - mpq_pkg::CNT_W'(1);
                end
            end
        end
    end

endmodule

// ===== src/mpq_store.sv =====
`timescale 1ns / 1ps
// Thread id store for all levels: one write port, one registered read port.
// Depends on mpq_pkg; the read register doubles as the picked-id output field.

module mpq_store (
    input  logic                       aclk,
    input  mpq_pkg::mpq_mem_req_t      mem_req,
    output logic [mpq_pkg::ID_W-1:0]   picked_thread
);

    logic [mpq_pkg::ID_W-1:0] mem [mpq_pkg::LEVELS * mpq_pkg::QUEUE_DEPTH];
    logic [mpq_pkg::ID_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    // Registered read, zero for anything but a successful pick
    always_ff @(posedge aclk) begin
        if (mem_req.adv) begin
            if (mem_req.rd_en) begin
                rd_data_reg <= mem[mem_req.rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    assign picked_thread = rd_data_reg;

endmodule

// ===== src/multilevel_priority_run_queue_top.sv =====
`timescale 1ns / 1ps
// Top level of the multilevel priority run queue: stream ports and result register.
// Depends on mpq_pkg, mpq_level_ctrl and mpq_store.

// Takes one request per clock unless the result is stalled and returns exactly one
// result per request, in the cycle after it is accepted. Enqueue (tuser 0) appends
// the id to its level's FIFO or answers full; pick (tuser 1) removes the oldest id
// of the highest non-empty level and returns it with its priority lowered by one
// (level 0 stays at 0, so it rotates round robin), or answers empty; flush (tuser 2) drops
// everything. Level state updates in the accept cycle and each request makes at
// most one store access (a write or a registered read), so back-to-back requests
// see each other's effect.
// s_tready is high whenever the result register is empty or being drained.

module multilevel_priority_run_queue_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mpq_pkg::S_TDATA_W-1:0]     s_tdata,  // thread_id[7:0], priority_req[9:8]
    input  logic [mpq_pkg::KIND_W-1:0]        s_tuser,  // kind[1:0]
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mpq_pkg::M_TDATA_W-1:0]     m_tdata   // picked_thread[7:0],
                                                        // next_priority[9:8], status[11:10]
);

    localparam int PAD_W = mpq_pkg::M_TDATA_W - mpq_pkg::ID_W - mpq_pkg::PRIO_W
                           - mpq_pkg::STATUS_W;

    mpq_pkg::mpq_mem_req_t             mem_req;
    logic                              accept;
    logic [mpq_pkg::ID_W-1:0]          picked_thread;
    logic [mpq_pkg::PRIO_W-1:0]        nextp_next;
    logic [mpq_pkg::STATUS_W-1:0]      status_next;
    logic [mpq_pkg::PRIO_W-1:0]        nextp_reg;
    logic [mpq_pkg::STATUS_W-1:0]      status_reg;
    logic                              valid_reg;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    mpq_level_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .kind          (s_tuser),
        .thread_id     (s_tdata[mpq_pkg::ID_W-1:0]),
        .priority_req  (s_tdata[mpq_pkg::ID_W +: mpq_pkg::PRIO_W]),
        .mem_req       (mem_req),
        .next_priority (nextp_next),
        .status        (status_next)
    );

    mpq_store u_store (
        .aclk          (aclk),
        .mem_req       (mem_req),
        .picked_thread (picked_thread)
    );

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            nextp_reg  <= nextp_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {PAD_W'(0), status_reg, nextp_reg, picked_thread};

endmodule

// ===== src/mpq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the multilevel priority run queue top level.
// Depends on mpq_pkg; bound to multilevel_priority_run_queue_top below.

module mpq_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [mpq_pkg::KIND_W-1:0]        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mpq_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic [mpq_pkg::STATUS_W-1:0] st;
    logic [mpq_pkg::ID_W-1:0]     picked;
    logic [mpq_pkg::PRIO_W-1:0]   nextp;
    logic                         s_acc;

    assign picked = m_tdata[mpq_pkg::ID_W-1:0];
    assign nextp  = m_tdata[mpq_pkg::ID_W +: mpq_pkg::PRIO_W];
    assign st     = m_tdata[mpq_pkg::ID_W + mpq_pkg::PRIO_W +: mpq_pkg::STATUS_W];
    assign s_acc  = s_tvalid && s_tready;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Every accepted request yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_tvalid)
        else $error("accepted request produced no result");

    // An empty result register never blocks the request side
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request side stalled with no pending result");

    // Failed requests carry zero fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (st != mpq_pkg::ST_OK)) |-> ((picked == '0) && (nextp == '0)))
        else $error("non-ok result with nonzero fields");

    // A pick never reports full
    a_pick_st: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tuser == mpq_pkg::KIND_PICK)) |=> (st != mpq_pkg::ST_FULL))
        else $error("pick answered with full status");

endmodule

bind multilevel_priority_run_queue_top mpq_checker u_mpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
